FILE: rtl/core/view_frustum_cull_test_assert.svh
// Assertion macros for the frustum culling checker.
`ifndef VIEW_FRUSTUM_CULL_TEST_ASSERT_SVH
`define VIEW_FRUSTUM_CULL_TEST_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define VFC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a condition in the cycle after its trigger.
`define VFC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/vfc_pkg.sv
// Shared types and constants of the six-plane frustum culling block.
`default_nettype none

package vfc_pkg;

   localparam int PLANE_COUNT   = 6;
   localparam int PLANE_BITS    = 64;
   localparam int NORM_BITS     = 16;
   localparam int D_SHIFT       = 14;
   localparam int CSR_ADDR_BITS = 3;
   localparam int FUNC_BITS     = 2;
   localparam int RSP_DATA_BITS = 8;

   // Test kinds carried in req_tuser; the unused code runs as a box test
   localparam logic [FUNC_BITS-1:0] FUNC_POINT  = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_SPHERE = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_BOX    = 2'd2;

   // Control that travels with each object down the chain of plane cells
   typedef struct packed {
      logic                 valid;
      logic                 visible;
      logic [FUNC_BITS-1:0] func;
   } cell_ctl_type;

endpackage

`default_nettype wire

FILE: rtl/core/view_frustum_cull_test.sv
// Six-plane view frustum culling test: top level with the chain of plane cells.
//
// The req_ channel carries one object per transaction: the test kind in
// req_tuser and the center and extents in req_tdata. The rsp_ channel
// returns one transaction per object, the visible flag in rsp_tdata bit 0,
// in the order the objects were taken.
// Planes are loaded through the csr_ port, one 64-bit word per plane
// (left, right, top, bottom, near, far); load them while no object is
// in flight. An address beyond the far plane is ignored.
// Each object walks through six plane cells of three stages each, and its
// result is registered in the last stage of the far-plane cell. One object
// is taken per cycle as long as the result side keeps up.
// When rsp_tready is low with a result waiting, the whole chain holds and
// req_tready drops in the same cycle; nothing is lost or repeated.
// Reset empties the chain and clears all planes to zero, which makes every
// object visible.
`default_nettype none

module view_frustum_cull_test #(
   parameter  int COORD_BITS     = 16,
   localparam int REQ_FIELD_BITS = 6 * COORD_BITS - 3,
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Object in
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // center_x, center_y, center_z, extent_x, extent_y, extent_z
   input  wire logic [REQ_DATA_BITS-1:0]             req_tdata,
   // func
   input  wire logic [vfc_pkg::FUNC_BITS-1:0]        req_tuser,
   // Result out
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // visible
   output logic [vfc_pkg::RSP_DATA_BITS-1:0]         rsp_tdata,
   // Plane writes
   input  wire logic                                 csr_we,
   input  wire logic [vfc_pkg::CSR_ADDR_BITS-1:0]    csr_addr,
   input  wire logic [vfc_pkg::PLANE_BITS-1:0]       csr_wdata
);

   localparam int CB = COORD_BITS;
   localparam int EB = COORD_BITS - 1;
   localparam int NP = vfc_pkg::PLANE_COUNT;

   logic                  advance;
   vfc_pkg::cell_ctl_type chain_ctl [NP+1];
   logic signed [CB-1:0]  chain_cx  [NP+1];
   logic signed [CB-1:0]  chain_cy  [NP+1];
   logic signed [CB-1:0]  chain_cz  [NP+1];
   logic [EB-1:0]         chain_ex  [NP+1];
   logic [EB-1:0]         chain_ey  [NP+1];
   logic [EB-1:0]         chain_ez  [NP+1];

   // Hold the whole chain while a result waits on the receiver
   assign advance    = ~rsp_tvalid | rsp_tready;
   assign req_tready = advance;

   // Unpack the object into the head of the chain
   assign chain_ctl[0].valid   = req_tvalid & advance;
   assign chain_ctl[0].visible = 1'b1;
   assign chain_ctl[0].func    = req_tuser;
   assign chain_cx[0] = $signed(req_tdata[0*CB +: CB]);
   assign chain_cy[0] = $signed(req_tdata[1*CB +: CB]);
   assign chain_cz[0] = $signed(req_tdata[2*CB +: CB]);
   assign chain_ex[0] = req_tdata[3*CB +: EB];
   assign chain_ey[0] = req_tdata[3*CB+EB +: EB];
   assign chain_ez[0] = req_tdata[3*CB+2*EB +: EB];

   // One cell per plane, in register order
   for (genvar k = 0; k < NP; k++) begin : g_cell
      logic wr_en;
      assign wr_en = csr_we && (csr_addr == vfc_pkg::CSR_ADDR_BITS'(k));

      vfc_cell #(
         .COORD_BITS (COORD_BITS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .wr_en   (wr_en),
         .wr_data (csr_wdata),
         .in_ctl  (chain_ctl[k]),
         .in_cx   (chain_cx[k]),
         .in_cy   (chain_cy[k]),
         .in_cz   (chain_cz[k]),
         .in_ex   (chain_ex[k]),
         .in_ey   (chain_ey[k]),
         .in_ez   (chain_ez[k]),
         .out_ctl (chain_ctl[k+1]),
         .out_cx  (chain_cx[k+1]),
         .out_cy  (chain_cy[k+1]),
         .out_cz  (chain_cz[k+1]),
         .out_ex  (chain_ex[k+1]),
         .out_ey  (chain_ey[k+1]),
         .out_ez  (chain_ez[k+1])
      );
   end

   // The last cell's stage registers are the output register
   assign rsp_tvalid = chain_ctl[NP].valid;
   assign rsp_tdata  = {(vfc_pkg::RSP_DATA_BITS-1)'(0), chain_ctl[NP].visible};

endmodule

`default_nettype wire

FILE: rtl/core/vfc_cell.sv
// One plane cell: holds a plane and tests each passing object in three stages.
`default_nettype none

module vfc_cell #(
   parameter int COORD_BITS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               advance,
   input  wire logic                               wr_en,
   input  wire logic [vfc_pkg::PLANE_BITS-1:0]     wr_data,
   input  wire vfc_pkg::cell_ctl_type              in_ctl,
   input  wire logic signed [COORD_BITS-1:0]       in_cx,
   input  wire logic signed [COORD_BITS-1:0]       in_cy,
   input  wire logic signed [COORD_BITS-1:0]       in_cz,
   input  wire logic [COORD_BITS-2:0]              in_ex,
   input  wire logic [COORD_BITS-2:0]              in_ey,
   input  wire logic [COORD_BITS-2:0]              in_ez,
   output vfc_pkg::cell_ctl_type                   out_ctl,
   output logic signed [COORD_BITS-1:0]            out_cx,
   output logic signed [COORD_BITS-1:0]            out_cy,
   output logic signed [COORD_BITS-1:0]            out_cz,
   output logic [COORD_BITS-2:0]                   out_ex,
   output logic [COORD_BITS-2:0]                   out_ey,
   output logic [COORD_BITS-2:0]                   out_ez
);

   localparam int NB  = vfc_pkg::NORM_BITS;
   localparam int PW  = COORD_BITS + NB;
   localparam int AW  = COORD_BITS + NB - 1;
   localparam int DW  = NB + vfc_pkg::D_SHIFT;
   localparam int SPW = COORD_BITS - 1 + vfc_pkg::D_SHIFT;
   localparam int SW  = ((PW > DW) ? PW : DW) + 3;

   // Plane coefficients and the normal magnitudes for the box bound
   logic [vfc_pkg::PLANE_BITS-1:0] plane_ff;
   logic [NB-1:0]                  nax_ff, nay_ff, naz_ff;

   logic signed [NB-1:0] nx, ny, nz;

   // Stage 1: products
   vfc_pkg::cell_ctl_type   s1_ctl_ff;
   logic signed [PW-1:0]    s1_px_ff, s1_py_ff, s1_pz_ff;
   logic signed [PW-1:0]    s1_px_in, s1_py_in, s1_pz_in;
   logic [AW-1:0]           s1_bx_ff, s1_by_ff, s1_bz_ff;
   logic [AW-1:0]           s1_bx_in, s1_by_in, s1_bz_in;
   logic signed [DW-1:0]    s1_d_ff, s1_d_in;
   logic [SPW-1:0]          s1_sph_ff, s1_sph_in;
   logic signed [COORD_BITS-1:0] s1_cx_ff, s1_cy_ff, s1_cz_ff;
   logic [COORD_BITS-2:0]        s1_ex_ff, s1_ey_ff, s1_ez_ff;
   logic                    is_box, is_sphere;

   // Stage 2: partial sums
   vfc_pkg::cell_ctl_type   s2_ctl_ff;
   logic signed [SW-1:0]    s2_a_ff, s2_b_ff, s2_c_ff, s2_e_ff;
   logic signed [SW-1:0]    s2_a_in, s2_b_in, s2_c_in, s2_e_in;
   logic signed [COORD_BITS-1:0] s2_cx_ff, s2_cy_ff, s2_cz_ff;
   logic [COORD_BITS-2:0]        s2_ex_ff, s2_ey_ff, s2_ez_ff;

   // Stage 3: verdict
   vfc_pkg::cell_ctl_type   s3_ctl_ff, s3_ctl_in;
   logic signed [SW-1:0]    s3_sum;
   logic signed [COORD_BITS-1:0] s3_cx_ff, s3_cy_ff, s3_cz_ff;
   logic [COORD_BITS-2:0]        s3_ex_ff, s3_ey_ff, s3_ez_ff;

   // Load the plane and precompute the normal magnitudes
   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff <= '0;
         nax_ff   <= '0;
         nay_ff   <= '0;
         naz_ff   <= '0;
      end else if (wr_en) begin
         plane_ff <= wr_data;
         nax_ff   <= wr_data[0*NB+NB-1] ? NB'(-wr_data[0*NB +: NB]) : wr_data[0*NB +: NB];
         nay_ff   <= wr_data[1*NB+NB-1] ? NB'(-wr_data[1*NB +: NB]) : wr_data[1*NB +: NB];
         naz_ff   <= wr_data[2*NB+NB-1] ? NB'(-wr_data[2*NB +: NB]) : wr_data[2*NB +: NB];
      end
   end

   assign nx = $signed(plane_ff[0*NB +: NB]);
   assign ny = $signed(plane_ff[1*NB +: NB]);
   assign nz = $signed(plane_ff[2*NB +: NB]);

   // Decode the test kind
   always_comb begin
      is_box    = 1'b0;
      is_sphere = 1'b0;
      unique case (in_ctl.func)
         vfc_pkg::FUNC_POINT:  is_box = 1'b0;
         vfc_pkg::FUNC_SPHERE: is_sphere = 1'b1;
         default:              is_box = 1'b1;
      endcase
   end

   // Form the center dot terms, the box bound and the sphere radius
   assign s1_px_in  = PW'(nx) * PW'(in_cx);
   assign s1_py_in  = PW'(ny) * PW'(in_cy);
   assign s1_pz_in  = PW'(nz) * PW'(in_cz);
   assign s1_bx_in  = is_box ? AW'(nax_ff) * AW'(in_ex) : '0;
   assign s1_by_in  = is_box ? AW'(nay_ff) * AW'(in_ey) : '0;
   assign s1_bz_in  = is_box ? AW'(naz_ff) * AW'(in_ez) : '0;
   assign s1_d_in   = $signed({plane_ff[3*NB +: NB], {vfc_pkg::D_SHIFT{1'b0}}});
   assign s1_sph_in = is_sphere ? {in_ex, {vfc_pkg::D_SHIFT{1'b0}}} : '0;

   // Add in pairs
   assign s2_a_in = SW'(s1_px_ff) + SW'(s1_py_ff);
   assign s2_b_in = SW'(s1_pz_ff) + SW'(s1_d_ff);
   assign s2_c_in = $signed(SW'(s1_bx_ff) + SW'(s1_by_ff));
   assign s2_e_in = $signed(SW'(s1_bz_ff) + SW'(s1_sph_ff));

   // Drop visibility when the best-case dot falls below zero
   always_comb begin
      s3_sum            = s2_a_ff + s2_b_ff + s2_c_ff + s2_e_ff;
      s3_ctl_in         = s2_ctl_ff;
      s3_ctl_in.visible = s2_ctl_ff.visible & ~s3_sum[SW-1];
   end

   // Advance the control of all three stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         s3_ctl_ff <= '0;
      end else if (advance) begin
         s1_ctl_ff <= in_ctl;
         s2_ctl_ff <= s1_ctl_ff;
         s3_ctl_ff <= s3_ctl_in;
      end
   end

   // Advance the payload of all three stages
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_px_ff  <= s1_px_in;
         s1_py_ff  <= s1_py_in;
         s1_pz_ff  <= s1_pz_in;
         s1_bx_ff  <= s1_bx_in;
         s1_by_ff  <= s1_by_in;
         s1_bz_ff  <= s1_bz_in;
         s1_d_ff   <= s1_d_in;
         s1_sph_ff <= s1_sph_in;
         s1_cx_ff  <= in_cx;
         s1_cy_ff  <= in_cy;
         s1_cz_ff  <= in_cz;
         s1_ex_ff  <= in_ex;
         s1_ey_ff  <= in_ey;
         s1_ez_ff  <= in_ez;
         s2_a_ff   <= s2_a_in;
         s2_b_ff   <= s2_b_in;
         s2_c_ff   <= s2_c_in;
         s2_e_ff   <= s2_e_in;
         s2_cx_ff  <= s1_cx_ff;
         s2_cy_ff  <= s1_cy_ff;
         s2_cz_ff  <= s1_cz_ff;
         s2_ex_ff  <= s1_ex_ff;
         s2_ey_ff  <= s1_ey_ff;
         s2_ez_ff  <= s1_ez_ff;
         s3_cx_ff  <= s2_cx_ff;
         s3_cy_ff  <= s2_cy_ff;
         s3_cz_ff  <= s2_cz_ff;
         s3_ex_ff  <= s2_ex_ff;
         s3_ey_ff  <= s2_ey_ff;
         s3_ez_ff  <= s2_ez_ff;
      end
   end

   assign out_ctl = s3_ctl_ff;
   assign out_cx  = s3_cx_ff;
   assign out_cy  = s3_cy_ff;
   assign out_cz  = s3_cz_ff;
   assign out_ex  = s3_ex_ff;
   assign out_ey  = s3_ey_ff;
   assign out_ez  = s3_ez_ff;

endmodule

`default_nettype wire

FILE: rtl/core/vfc_checker.sv
// Port-level checks for the frustum culling block, bound to its top level.
`default_nettype none

`include "view_frustum_cull_test_assert.svh"

module vfc_checker #(
   parameter  int COORD_BITS     = 16,
   localparam int REQ_FIELD_BITS = 6 * COORD_BITS - 3,
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8
) (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic [REQ_DATA_BITS-1:0]          req_tdata,
   input wire logic [vfc_pkg::FUNC_BITS-1:0]     req_tuser,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [vfc_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   // A stalled result stays put
   `VFC_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")

   // A stalled result blocks new transactions
   `VFC_ASSERT_SAME(a_req_block, rsp_tvalid && !rsp_tready, !req_tready, "object taken while result stalled")

   // An empty output register never blocks the input
   `VFC_ASSERT_SAME(a_req_open, !rsp_tvalid, req_tready, "input blocked with no result waiting")

   // Reset leaves no result behind
   `VFC_ASSERT_SAME(a_rst_empty, $fell(reset), !rsp_tvalid, "result present right after reset")

endmodule

bind view_frustum_cull_test vfc_checker #(.COORD_BITS(COORD_BITS)) u_vfc_checker (.*);

`default_nettype wire

FILE: bench/tb.sv
// Self-checking bench for the six-plane frustum culling block.
`timescale 1ns / 100ps

module tb;

   localparam int COORD_BITS     = 16;
   localparam int EXT_BITS       = COORD_BITS - 1;
   localparam int REQ_DATA_BITS  = ((6 * COORD_BITS - 3 + 7) / 8) * 8;
   localparam int PHASE_COUNT    = 6;
   localparam int PHASE_OBJECTS  = 175;
   localparam int DRAIN_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT = 2000;

   // Selector code with no test of its own; the block runs it as a box test
   localparam logic [vfc_pkg::FUNC_BITS-1:0] FUNC_SPARE = 2'd3;

   // Q1.14 unit normal
   localparam int NORM_ONE = 1 << vfc_pkg::D_SHIFT;

   typedef enum logic [vfc_pkg::CSR_ADDR_BITS-1:0] {
      PLANE_LEFT,
      PLANE_RIGHT,
      PLANE_TOP,
      PLANE_BOTTOM,
      PLANE_NEAR,
      PLANE_FAR,
      ADDR_SPARE_LO,
      ADDR_SPARE_HI
   } plane_addr_type;

   typedef struct {
      logic [vfc_pkg::FUNC_BITS-1:0] func;
      logic signed [COORD_BITS-1:0]  cx;
      logic signed [COORD_BITS-1:0]  cy;
      logic signed [COORD_BITS-1:0]  cz;
      logic [EXT_BITS-1:0]           ex;
      logic [EXT_BITS-1:0]           ey;
      logic [EXT_BITS-1:0]           ez;
   } object_type;

   logic                                  clock      = 1'b0;
   logic                                  reset      = 1'b1;
   logic                                  req_tvalid = 1'b0;
   logic                                  req_tready;
   logic [REQ_DATA_BITS-1:0]              req_tdata  = '0;
   logic [vfc_pkg::FUNC_BITS-1:0]         req_tuser  = '0;
   logic                                  rsp_tvalid;
   logic                                  rsp_tready = 1'b0;
   logic [vfc_pkg::RSP_DATA_BITS-1:0]     rsp_tdata;
   logic                                  csr_we     = 1'b0;
   logic [vfc_pkg::CSR_ADDR_BITS-1:0]     csr_addr   = '0;
   logic [vfc_pkg::PLANE_BITS-1:0]        csr_wdata  = '0;

   // Predictor copy of the plane registers and the planes to load next
   logic [vfc_pkg::PLANE_BITS-1:0] plane_word [vfc_pkg::PLANE_COUNT] = '{default: '0};
   logic [vfc_pkg::PLANE_BITS-1:0] next_plane [vfc_pkg::PLANE_COUNT];

   object_type pending_objects [$];
   bit         expected_visible [$];
   object_type drive_obj;
   bit         held_visible;
   int         outstanding   = 0;
   int         error_count   = 0;
   int         send_idle_pct = 0;
   int         rsp_stall_pct = 0;
   int         idle_cycles   = 0;

   view_frustum_cull_test #(
      .COORD_BITS (COORD_BITS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      // center_x, center_y, center_z, extent_x, extent_y, extent_z
      .req_tdata  (req_tdata),
      // func
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      // visible
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // Plane evaluation at 14 fraction bits, exact in 64 bits
   function automatic longint plane_dot(int p, longint x, longint y, longint z);
      logic signed [vfc_pkg::NORM_BITS-1:0] nx, ny, nz, dd;
      nx = plane_word[p][15:0];
      ny = plane_word[p][31:16];
      nz = plane_word[p][47:32];
      dd = plane_word[p][63:48];
      return longint'(nx) * x + longint'(ny) * y + longint'(nz) * z
             + (longint'(dd) <<< vfc_pkg::D_SHIFT);
   endfunction

   function automatic bit predict_visible(object_type o);
      longint cx, cy, cz, ex, ey, ez, x, y, z;
      bit     vis, any_in;
      cx  = longint'(o.cx);
      cy  = longint'(o.cy);
      cz  = longint'(o.cz);
      ex  = longint'(o.ex);
      ey  = longint'(o.ey);
      ez  = longint'(o.ez);
      vis = 1'b1;
      for (int p = 0; p < vfc_pkg::PLANE_COUNT; p++) begin
         case (o.func)
            vfc_pkg::FUNC_POINT: begin
               if (plane_dot(p, cx, cy, cz) < 0) vis = 1'b0;
            end
            vfc_pkg::FUNC_SPHERE: begin
               if (plane_dot(p, cx, cy, cz) < -(ex <<< vfc_pkg::D_SHIFT)) vis = 1'b0;
            end
            default: begin
               // Cull only when every corner lies behind this plane
               any_in = 1'b0;
               for (int c = 0; c < 8; c++) begin
                  x = ((c & 1) != 0) ? cx + ex : cx - ex;
                  y = ((c & 2) != 0) ? cy + ey : cy - ey;
                  z = ((c & 4) != 0) ? cz + ez : cz - ez;
                  if (plane_dot(p, x, y, z) >= 0) any_in = 1'b1;
               end
               if (!any_in) vis = 1'b0;
            end
         endcase
      end
      return vis;
   endfunction

   function automatic object_type make_object(logic [vfc_pkg::FUNC_BITS-1:0] func,
                                              int cx, int cy, int cz,
                                              int ex, int ey, int ez);
      object_type o;
      o.func = func;
      o.cx   = COORD_BITS'(cx);
      o.cy   = COORD_BITS'(cy);
      o.cz   = COORD_BITS'(cz);
      o.ex   = EXT_BITS'(ex);
      o.ey   = EXT_BITS'(ey);
      o.ez   = EXT_BITS'(ez);
      return o;
   endfunction

   // Objects scattered around the scene, many near the plane boundaries
   function automatic object_type scene_object();
      return make_object(vfc_pkg::FUNC_BITS'($urandom_range(0, 3)),
                         int'($urandom_range(0, 12000)) - 6000,
                         int'($urandom_range(0, 12000)) - 6000,
                         int'($urandom_range(0, 12000)) - 6000,
                         $urandom_range(0, 1500), $urandom_range(0, 1500),
                         $urandom_range(0, 1500));
   endfunction

   // Full-range objects: every field bit free
   function automatic object_type noise_object();
      return make_object(vfc_pkg::FUNC_BITS'($urandom_range(0, 3)),
                         $urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom(), $urandom());
   endfunction

   function automatic logic [vfc_pkg::PLANE_BITS-1:0] make_plane(int nx, int ny, int nz,
                                                                 int d);
      return {16'(d), 16'(nz), 16'(ny), 16'(nx)};
   endfunction

   // Near-axis plane facing inward, with a random reach from the origin
   function automatic logic [vfc_pkg::PLANE_BITS-1:0] axis_plane(int axis, bit neg);
      int comp [3];
      for (int i = 0; i < 3; i++) comp[i] = int'($urandom_range(0, 4000)) - 2000;
      comp[axis] = NORM_ONE - int'($urandom_range(0, 1500));
      if (neg) comp[axis] = -comp[axis];
      return make_plane(comp[0], comp[1], comp[2], $urandom_range(64, 4000));
   endfunction

   task automatic build_frustum();
      next_plane[PLANE_LEFT]   = axis_plane(0, 1'b0);
      next_plane[PLANE_RIGHT]  = axis_plane(0, 1'b1);
      next_plane[PLANE_TOP]    = axis_plane(1, 1'b1);
      next_plane[PLANE_BOTTOM] = axis_plane(1, 1'b0);
      next_plane[PLANE_NEAR]   = axis_plane(2, 1'b0);
      next_plane[PLANE_FAR]    = axis_plane(2, 1'b1);
   endtask

   task automatic report(input string msg);
      $display("ERROR at %0t ns: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic write_csr(input plane_addr_type a,
                            input logic [vfc_pkg::PLANE_BITS-1:0] w);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= a;
      csr_wdata <= w;
      if (a < vfc_pkg::PLANE_COUNT) plane_word[a] = w;
   endtask

   // Load all six planes, then a write to an unused index that must be ignored
   task automatic load_planes(input plane_addr_type spare);
      for (int i = 0; i < vfc_pkg::PLANE_COUNT; i++)
         write_csr(plane_addr_type'(i), next_plane[i]);
      write_csr(spare, {$urandom(), $urandom()});
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_object(input object_type o);
      pending_objects.push_back(o);
      outstanding++;
   endtask

   // Hold until every queued object has returned its result
   task automatic drain();
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin send_idle_pct = 75; rsp_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  rsp_stall_pct = 75; end
         default: begin send_idle_pct = 38; rsp_stall_pct = 38; end
      endcase
   endtask

   // Driver: record the accepted transaction, then present the next object
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) expected_visible.push_back(held_visible);
         if (!req_tvalid || req_tready) begin
            if (pending_objects.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               drive_obj    = pending_objects.pop_front();
               held_visible = predict_visible(drive_obj);
               req_tvalid   <= 1'b1;
               req_tuser    <= drive_obj.func;
               req_tdata    <= {3'b000, drive_obj.ez, drive_obj.ey, drive_obj.ex,
                                drive_obj.cz, drive_obj.cy, drive_obj.cx};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Monitor: check each result transaction against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_visible.size() == 0) begin
            report($sformatf("result with nothing expected, visible %0b", rsp_tdata[0]));
         end else begin
            if (rsp_tdata[0] !== expected_visible[0])
               report($sformatf("visible mismatch: got %0b expected %0b",
                                rsp_tdata[0], expected_visible[0]));
            void'(expected_visible.pop_front());
            outstanding--;
         end
      end
   end

   // Watchdog: end the run when work is pending but nothing moves
   always @(posedge clock) begin
      if (reset || outstanding == 0 || (req_tvalid && req_tready) ||
          (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d results outstanding", outstanding);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      bit structured;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      set_idling(0);

      // Planes at reset are zero: everything is visible, field extremes included
      send_object(make_object(vfc_pkg::FUNC_POINT, 0, 0, 0, 0, 0, 0));
      send_object(make_object(vfc_pkg::FUNC_POINT, -32768, -32768, -32768,
                              32767, 32767, 32767));
      send_object(make_object(vfc_pkg::FUNC_SPHERE, 32767, 32767, 32767, 32767, 0, 0));
      send_object(make_object(vfc_pkg::FUNC_SPHERE, -32768, 32767, -32768,
                              0, 32767, 32767));
      send_object(make_object(vfc_pkg::FUNC_BOX, -32768, -32768, -32768,
                              32767, 32767, 32767));
      send_object(make_object(vfc_pkg::FUNC_BOX, 32767, 32767, 32767, 0, 0, 0));
      send_object(make_object(FUNC_SPARE, 32767, -32768, 32767, 32767, 32767, 32767));
      send_object(make_object(FUNC_SPARE, 0, 0, 0, 0, 0, 0));
      drain();

      // Exact axis-aligned frustum: probe objects right on and just past the left plane
      next_plane[PLANE_LEFT]   = make_plane(NORM_ONE, 0, 0, 1600);
      next_plane[PLANE_RIGHT]  = make_plane(-NORM_ONE, 0, 0, 1600);
      next_plane[PLANE_TOP]    = make_plane(0, -NORM_ONE, 0, 1600);
      next_plane[PLANE_BOTTOM] = make_plane(0, NORM_ONE, 0, 1600);
      next_plane[PLANE_NEAR]   = make_plane(0, 0, NORM_ONE, 1600);
      next_plane[PLANE_FAR]    = make_plane(0, 0, -NORM_ONE, 1600);
      load_planes(ADDR_SPARE_LO);
      send_object(make_object(vfc_pkg::FUNC_POINT, 0, 0, 0, 0, 0, 0));
      send_object(make_object(vfc_pkg::FUNC_POINT, -1600, 0, 0, 0, 0, 0));
      send_object(make_object(vfc_pkg::FUNC_POINT, -1601, 0, 0, 0, 0, 0));
      send_object(make_object(vfc_pkg::FUNC_SPHERE, -1700, 0, 0, 100, 0, 0));
      send_object(make_object(vfc_pkg::FUNC_SPHERE, -1700, 0, 0, 99, 0, 0));
      send_object(make_object(vfc_pkg::FUNC_BOX, -1700, 0, 0, 100, 5, 5));
      send_object(make_object(vfc_pkg::FUNC_BOX, -1700, 0, 0, 99, 5, 5));
      send_object(make_object(FUNC_SPARE, -1700, 0, 0, 100, 5, 5));

      // Phases of random objects, each with a newly loaded plane set and an idling pattern
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         drain();
         structured = 1'b0;
         case (phase)
            1: begin
               for (int i = 0; i < vfc_pkg::PLANE_COUNT; i++) next_plane[i] = '1;
            end
            3: begin
               for (int i = 0; i < vfc_pkg::PLANE_COUNT; i++)
                  next_plane[i] = (i % 2 == 0) ? 64'h7FFF_7FFF_7FFF_7FFF
                                               : 64'h8000_8000_8000_8000;
            end
            4: begin
               for (int i = 0; i < vfc_pkg::PLANE_COUNT; i++)
                  next_plane[i] = {$urandom(), $urandom()};
            end
            default: begin
               build_frustum();
               structured = 1'b1;
            end
         endcase
         load_planes((phase % 2 == 0) ? ADDR_SPARE_HI : ADDR_SPARE_LO);
         set_idling(phase % 4);
         for (int k = 0; k < PHASE_OBJECTS; k++) begin
            if ($urandom_range(0, 99) < (structured ? 85 : 50))
               send_object(scene_object());
            else
               send_object(noise_object());
         end
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
